// ===== src/swd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swd_pkg;

  localparam int DEFAULT_MAX_WINDOW  = 64;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_THRESHOLD     = 3'd0;
  localparam cfg_idx_t REG_BAND_WIDTH    = 3'd1;
  localparam cfg_idx_t REG_WINDOW_LENGTH = 3'd2;
  localparam cfg_idx_t REG_MIN_COUNT     = 3'd3;
  localparam cfg_idx_t REG_COUNT_OFFSET  = 3'd4;

  localparam int THRESHOLD_W    = 16;
  localparam int BAND_WIDTH_W   = 15;
  localparam int WINDOW_LEN_W   = 7;
  localparam int MIN_COUNT_W    = 7;
  localparam int COUNT_OFFSET_W = 6;

  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LENGTH_RST = 7'd64;
  localparam logic [MIN_COUNT_W-1:0]  MIN_COUNT_RST     = 7'd1;

endpackage

`default_nettype wire

// ===== src/sliding_window_out_of_band_detector.sv =====
`timescale 1ns / 1ps
// Sliding-window out-of-band (m-of-n) detector.
// A request moves through stage 1 and the output register before out_valid_o shows it.
// Throughput: one request per cycle unless out_stall_i holds the output; each request
// reads and writes its window entry in one RAM access; the count updates per request.
// Reset: window empty, registers at their defaults (length 64, min count 1, others 0).
// No RAM clearing pass: an entry's old flag is only used after it was written.
`default_nettype none

module sliding_window_out_of_band_detector #(
  parameter int MAX_WINDOW  = swd_pkg::DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = swd_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // sample requests
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]    sample_i,
  // results
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  impact_o,
  // register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [swd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [swd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import swd_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  // common width for comparing the 7-bit length register against MAX_WINDOW
  localparam int CMPL_W = (LEN_W > WINDOW_LEN_W) ? LEN_W : WINDOW_LEN_W;
  // common width for offset + total vs min count
  localparam int SUM_W  = ((LEN_W > MIN_COUNT_W) ? LEN_W : MIN_COUNT_W) + 1;
  // band test width: wide enough that thr +/- width never wraps
  localparam int BAND_W = ((SAMPLE_BITS > THRESHOLD_W + 1) ? SAMPLE_BITS : THRESHOLD_W + 1) + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [THRESHOLD_W-1:0]    threshold_q;
  logic        [BAND_WIDTH_W-1:0]   band_width_q;
  logic        [WINDOW_LEN_W-1:0]   window_length_q;
  logic        [MIN_COUNT_W-1:0]    min_count_q;
  logic        [COUNT_OFFSET_W-1:0] count_offset_q;

  logic cfg_we;
  logic win_clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  // Any write to the length register restarts the window, even the same value.
  assign win_clear   = cfg_we && (cfg_index_i == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= '0;
      band_width_q    <= '0;
      window_length_q <= WINDOW_LENGTH_RST;
      min_count_q     <= MIN_COUNT_RST;
      count_offset_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_THRESHOLD:     threshold_q     <= cfg_data_i[THRESHOLD_W-1:0];
        REG_BAND_WIDTH:    band_width_q    <= cfg_data_i[BAND_WIDTH_W-1:0];
        REG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WINDOW_LEN_W-1:0];
        REG_MIN_COUNT:     min_count_q     <= cfg_data_i[MIN_COUNT_W-1:0];
        REG_COUNT_OFFSET:  count_offset_q  <= cfg_data_i[COUNT_OFFSET_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Effective window length: zero acts as one, saturates at MAX_WINDOW.
  logic [CMPL_W-1:0] wl_ext;
  logic [LEN_W-1:0]  eff_len;

  assign wl_ext = CMPL_W'(window_length_q);

  always_comb begin
    if (window_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > CMPL_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = wl_ext[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  //   stage 1: RAM read of the evicted flag is in flight
  //   output register: finished result waiting to be taken
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_move;
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Stage 0: band test, ring position, fill level; RAM read-modify-write
  // ---------------------------------------------------------------------------
  logic signed [BAND_W-1:0] s_ext;
  logic signed [BAND_W-1:0] thr_ext;
  logic signed [BAND_W-1:0] w_ext;
  logic                     flag;

  assign s_ext   = BAND_W'(sample_i);
  assign thr_ext = BAND_W'(threshold_q);
  assign w_ext   = BAND_W'(signed'({1'b0, band_width_q}));
  assign flag    = (s_ext <= thr_ext - w_ext) || (s_ext >= thr_ext + w_ext);

  logic [PTR_W-1:0] write_pos_q, write_pos_d;
  logic [LEN_W-1:0] fill_level_q, fill_level_d;
  logic [PTR_W-1:0] pos;
  logic [LEN_W-1:0] pos_inc;
  logic             full_before;
  logic             full_after;

  always_comb begin
    pos = (LEN_W'(write_pos_q) >= eff_len) ? '0 : write_pos_q;
    pos_inc     = LEN_W'(pos) + LEN_W'(1);
    full_before = (fill_level_q >= eff_len);
    fill_level_d = full_before ? fill_level_q : fill_level_q + LEN_W'(1);
    full_after   = (fill_level_d == eff_len);
    write_pos_d  = (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q  <= '0;
      fill_level_q <= '0;
    end else if (win_clear) begin
      write_pos_q  <= '0;
      fill_level_q <= '0;
    end else if (in_accept) begin
      write_pos_q  <= write_pos_d;
      fill_level_q <= fill_level_d;
    end
  end

  // Read-first RAM: the old flag at pos comes back next cycle while the
  // new flag lands in the same entry, so back-to-back requests never collide.
  logic old_flag;

  swd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (pos),
    .wdata_i (flag),
    .re_i    (in_accept),
    .raddr_i (pos),
    .rdata_o (old_flag)
  );

  // Stage 1 payload
  logic s1_flag_q;
  logic s1_evict_q;
  logic s1_full_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_flag_q  <= flag;
      s1_evict_q <= full_before;
      s1_full_q  <= full_after;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: running count update and impact decision
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] outside_total_q, outside_total_d;
  logic [SUM_W-1:0] total_sum;
  logic             impact_d;
  logic             impact_q;

  always_comb begin
    outside_total_d = outside_total_q
                      - LEN_W'(s1_evict_q & old_flag)
                      + LEN_W'(s1_flag_q);
    total_sum = SUM_W'(count_offset_q) + SUM_W'(outside_total_d);
    impact_d  = s1_full_q && (total_sum >= SUM_W'(min_count_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_total_q <= '0;
    end else if (win_clear) begin
      outside_total_q <= '0;
    end else if (s1_move) begin
      outside_total_q <= outside_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      impact_q <= impact_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign impact_o    = impact_q;

endmodule

`default_nettype wire

// ===== src/swd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read and write to the same address return the old contents.
module swd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import swd_pkg::*;

  localparam int SW        = DEFAULT_SAMPLE_BITS;
  localparam int MAXW      = DEFAULT_MAX_WINDOW;
  localparam int LONG_HOLD = 160;  // receiver hold-off, long enough to back up the pipe

  // How often a side idles between requests.
  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [SW-1:0]  sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  impact_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  sliding_window_out_of_band_detector u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .impact_o   (impact_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the detector: register copies plus the flag ring, running count
  // and fill level. Updated at the edge where a sample request is accepted.
  // ---------------------------------------------------------------------------
  logic signed [THRESHOLD_W-1:0] thr_q  = '0;
  logic [BAND_WIDTH_W-1:0]       bw_q   = '0;
  logic [WINDOW_LEN_W-1:0]       wlen_q = WINDOW_LENGTH_RST;
  logic [MIN_COUNT_W-1:0]        minc_q = MIN_COUNT_RST;
  logic [COUNT_OFFSET_W-1:0]     coff_q = '0;

  logic ring_flags [MAXW];
  int   ring_pos  = 0;
  int   filled    = 0;
  int   ones_held = 0;

  // Stimulus and scoreboard state.
  logic signed [SW-1:0] sample_backlog [$];
  logic                 impact_due     [$];
  pace_e tx_pace = PACE_FULL;
  pace_e rx_pace = PACE_FULL;
  int    tx_wait = 0;
  int    rx_wait = 0;
  logic  impact_want;
  int    mismatches   = 0;
  int    samples_sent = 0;
  int    results_seen = 0;
  int    impacts_seen = 0;
  int    reg_writes   = 0;

  function automatic int window_span();
    if (wlen_q == 0) return 1;
    if (int'(wlen_q) > MAXW) return MAXW;
    return int'(wlen_q);
  endfunction

  // Folds one sample into the shadow window and returns the impact it yields.
  function automatic logic next_impact(input logic signed [SW-1:0] s);
    int   len;
    int   sv;
    int   tv;
    int   wv;
    int   pos;
    logic outside;
    len = window_span();
    sv  = s;
    tv  = thr_q;
    wv  = int'(bw_q);
    // band edges are themselves out of band; int math cannot overflow here
    outside = (sv <= tv - wv) || (sv >= tv + wv);
    pos = (ring_pos >= len) ? 0 : ring_pos;
    if (filled < len) begin
      filled++;
    end else begin
      ones_held -= int'(ring_flags[pos]);
    end
    ring_flags[pos] = outside;
    ones_held += int'(outside);
    ring_pos = (pos + 1 >= len) ? 0 : pos + 1;
    return (filled == len) && (int'(coff_q) + ones_held >= int'(minc_q));
  endfunction

  // Register write into the shadow; any window_length write restarts the window,
  // indexes past the last register are dropped.
  function automatic void shadow_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_THRESHOLD:     thr_q  = d[THRESHOLD_W-1:0];
      REG_BAND_WIDTH:    bw_q   = d[BAND_WIDTH_W-1:0];
      REG_WINDOW_LENGTH: begin
        wlen_q    = d[WINDOW_LEN_W-1:0];
        ring_pos  = 0;
        filled    = 0;
        ones_held = 0;
      end
      REG_MIN_COUNT:     minc_q = d[MIN_COUNT_W-1:0];
      REG_COUNT_OFFSET:  coff_q = d[COUNT_OFFSET_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int draw_wait(input pace_e pace);
    case (pace)
      PACE_FULL:  return 0;
      PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
      default:    return int'($urandom_range(0, 12));
    endcase
  endfunction

  // Sample aimed mostly at the band edges and the band itself, some full range.
  function automatic logic signed [SW-1:0] pick_sample();
    int v;
    int t;
    int w;
    t = thr_q;
    w = int'(bw_q);
    case ($urandom_range(0, 9))
      0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
      2:       v = t - w;
      3:       v = t + w;
      4:       v = t - w + 1;
      5:       v = t + w - 1;
      default: v = t - (w + 1) + int'($urandom_range(0, 2 * w + 2));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return SW'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: offers the backlog one request at a time, with a random
  // number of idle cycles drawn per request. A stalled request is held as is.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        // request taken at this edge: predict its result now
        impact_due = {impact_due, next_impact(sample_i)};
        samples_sent++;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (sample_backlog.size() > 0) begin
        sample_i   <= sample_backlog.pop_front();
        in_valid_i <= 1'b1;
        tx_wait = draw_wait(tx_pace);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks every accepted result against the oldest prediction
  // and draws the stall that follows it. Twice in the run it holds off for a
  // LONG_HOLD wait so the detector fills and stalls the sample side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (impact_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual impact=%0b",
                   $time, impact_o);
          mismatches++;
        end else begin
          impact_want = impact_due.pop_front();
          if (impact_o !== impact_want) begin
            $display("%0t: impact mismatch, expected %0b, actual %0b",
                     $time, impact_want, impact_o);
            mismatches++;
          end
        end
        results_seen++;
        if (impact_o === 1'b1) impacts_seen++;
        rx_wait = draw_wait(rx_pace);
        if (results_seen == 300 || results_seen == 1200) rx_wait = LONG_HOLD;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait > 0);
    end
  end

  // One register write over the config channel; shadow follows at the handshake.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    shadow_write(idx, d);
    reg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every request is taken and every result checked.
  task automatic drain();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || in_valid_i || impact_due.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // New random settings between phases; the window is kept about a third
  // of the time so old flags meet a new band.
  task automatic random_settings();
    int len;
    int v;
    case ($urandom_range(0, 5))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'($urandom_range(0, 65535)) - 32768;
      default: v = int'($urandom_range(0, 4000)) - 2000;
    endcase
    write_reg(REG_THRESHOLD, 16'(v));
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 32767;
      2:       v = int'($urandom_range(0, 32767));
      default: v = int'($urandom_range(0, 300));
    endcase
    write_reg(REG_BAND_WIDTH, {1'($urandom), 15'(v)});
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0:       v = 0;                          // reads as length 1
        1:       v = 64;
        2:       v = int'($urandom_range(65, 127));  // saturates
        3:       v = 1;
        default: v = int'($urandom_range(2, 16));
      endcase
      write_reg(REG_WINDOW_LENGTH, {9'($urandom), 7'(v)});
    end
    len = window_span();
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 127;
      default: v = int'($urandom_range(0, len + 1));
    endcase
    write_reg(REG_MIN_COUNT, {9'($urandom), 7'(v)});
    case ($urandom_range(0, 5))
      0:       v = 63;
      1:       v = int'($urandom_range(0, len));
      default: v = 0;
    endcase
    write_reg(REG_COUNT_OFFSET, {10'($urandom), 6'(v)});
    if ($urandom_range(0, 3) == 0)
      write_reg(cfg_idx_t'(REG_COUNT_OFFSET + $urandom_range(1, 3)), 16'($urandom));
  endtask

  initial begin : stimulus
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset settings first: every sample is out of band, the
    // 64-deep window never fills here, so impact stays low.
    tx_pace = PACE_LIGHT;
    rx_pace = PACE_LIGHT;
    @(negedge clk_i);
    sample_backlog = {16'sh0000, 16'shFFFF, 16'sh7FFF};
    drain();

    // Band (50,150) open: both edges count as out of band.
    write_reg(REG_THRESHOLD, 16'd100);
    write_reg(REG_BAND_WIDTH, 16'd50);
    write_reg(REG_WINDOW_LENGTH, 16'd4);
    write_reg(REG_MIN_COUNT, 16'd2);
    write_reg(REG_COUNT_OFFSET, 16'd0);
    @(negedge clk_i);
    sample_backlog = {16'sd50, 16'sd51, 16'sd149, 16'sd150,
                      16'sh8000, 16'sh7FFF, 16'sd100, 16'sd0};
    drain();

    // Min count zero on a full window: impact on every request.
    write_reg(REG_MIN_COUNT, 16'd0);
    @(negedge clk_i);
    sample_backlog = {16'sd100, 16'sd101};
    drain();

    // Same length written again still empties the window.
    write_reg(REG_WINDOW_LENGTH, 16'd4);
    @(negedge clk_i);
    sample_backlog = {16'sd100, 16'sd150};
    drain();

    // Lowest threshold, widest band (upper data bit masked off), length 0 -> 1.
    write_reg(REG_THRESHOLD, 16'h8000);
    write_reg(REG_BAND_WIDTH, 16'hFFFF);
    write_reg(REG_WINDOW_LENGTH, 16'd0);
    write_reg(REG_MIN_COUNT, 16'd64);
    write_reg(REG_COUNT_OFFSET, 16'd63);
    @(negedge clk_i);
    sample_backlog = {16'sh8000, 16'shFFFF, 16'sh7FFF, 16'shFFFE};
    drain();

    // Highest threshold, length above the maximum, writes to unused indexes.
    write_reg(REG_THRESHOLD, 16'h7FFF);
    write_reg(REG_BAND_WIDTH, 16'h7FFF);
    write_reg(REG_WINDOW_LENGTH, 16'd127);
    write_reg(REG_MIN_COUNT, 16'd127);
    write_reg(REG_COUNT_OFFSET, 16'd0);
    for (int k = 1; k <= 3; k++)
      write_reg(cfg_idx_t'(REG_COUNT_OFFSET + k), 16'($urandom));
    @(negedge clk_i);
    sample_backlog = {16'sd0, 16'sd1, 16'sh7FFF};
    drain();

    // Random part: twelve phases, the first with no idling on either side.
    for (int ph = 0; ph < 12; ph++) begin
      random_settings();
      tx_pace = (ph == 0) ? PACE_FULL : pace_e'($urandom_range(0, 2));
      rx_pace = (ph == 0) ? PACE_FULL : pace_e'($urandom_range(0, 2));
      n = $urandom_range(135, 170);
      @(negedge clk_i);
      repeat (n) sample_backlog = {sample_backlog, pick_sample()};
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("run covered %0d sample requests and %0d results (%0d with impact),",
             samples_sent, results_seen, impacts_seen);
    $display("with %0d register writes and %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0 && impact_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", impact_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
src/swd_pkg.sv
src/swd_ram.sv
src/sliding_window_out_of_band_detector.sv
tb/tb.sv
